>>> design/opwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package opwd_pkg;

    localparam int ERR_W     = 16;
    localparam int FRAC_BITS = 12;
    localparam int GAIN_W    = 16;
    localparam int DUTY_W    = 14;
    localparam int ACC_W     = 16;
    localparam int SLOPE_W   = 24;
    localparam int PID_W     = 28;
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 16;
    localparam int PROD_W    = 48;
    localparam int MUL_CNT_W = 4;
    localparam int DIV_N_W   = 27;
    localparam int DIV_D_W   = 14;
    localparam int DIV_CNT_W = 5;
    localparam int PCT_W     = 15;

    localparam logic [MUL_B_W-1:0] INV_SQRT2_Q16 = 16'd46341;
    localparam logic [MUL_B_W-1:0] RADIUS_Q16    = 16'd8847;
    localparam logic [DIV_D_W-1:0] INTEG_DIV     = 14'd20;
    localparam logic [DIV_D_W-1:0] REMAP_DIV     = 14'd10000;
    localparam logic [DUTY_W-1:0]  DUTY_FLOOR    = 14'd5000;
    localparam logic [DUTY_W-1:0]  DUTY_TOP      = 14'd10000;
    localparam logic [PCT_W-1:0]   DEAD_ZONE     = 15'd200;
    localparam logic [PCT_W-1:0]   PCT_CAP       = 15'd20000;

    localparam logic [GAIN_W-1:0] RST_KP_XY  = 16'd9830;
    localparam logic [GAIN_W-1:0] RST_KI_XY  = 16'd1638;
    localparam logic [GAIN_W-1:0] RST_KD_XY  = 16'd4096;
    localparam logic [GAIN_W-1:0] RST_KP_YAW = 16'd14418;
    localparam logic [GAIN_W-1:0] RST_KI_YAW = 16'd1638;
    localparam logic [GAIN_W-1:0] RST_KD_YAW = 16'd4915;
    localparam logic [DUTY_W-1:0] RST_CEIL   = 14'd10000;
    localparam logic [GAIN_W-1:0] RST_STP    = 16'd14047;

    typedef enum logic [2:0] {
        REG_KP_XY  = 3'd0,
        REG_KI_XY  = 3'd1,
        REG_KD_XY  = 3'd2,
        REG_KP_YAW = 3'd3,
        REG_KI_YAW = 3'd4,
        REG_KD_YAW = 3'd5,
        REG_CEIL   = 3'd6,
        REG_STP    = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AX_PREP,
        S_AX_INC,
        S_AX_MP,
        S_AX_MI,
        S_AX_MD,
        S_AX_END,
        S_MX_A,
        S_MX_B,
        S_MX_C,
        S_WH_PREP,
        S_WH_MUL,
        S_WH_SCL,
        S_WH_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0]        b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

endpackage
`default_nettype wire

>>> design/opwd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module opwd_mul (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire opwd_pkg::mul_req_t                req,
    output logic                                   done,
    output logic signed [opwd_pkg::PROD_W-1:0]     p
);
    import opwd_pkg::*;

    // shift-add, one multiplier bit per cycle
    logic signed [PROD_W-1:0] a_sh_reg;
    logic [MUL_B_W-1:0]       b_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic [MUL_CNT_W-1:0]     cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_sh_reg <= PROD_W'(req.a);
            b_reg    <= req.b;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + a_sh_reg;
            a_sh_reg <= a_sh_reg <<< 1;
            b_reg    <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule
`default_nettype wire

>>> design/opwd_div.sv
`timescale 1ns / 1ps
`default_nettype none
module opwd_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire opwd_pkg::div_req_t             req,
    output logic                                done,
    output logic [opwd_pkg::DIV_N_W-1:0]        q
);
    import opwd_pkg::*;

    // restoring division, one quotient bit per cycle
    logic [DIV_N_W-1:0]   nq_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     trial;
    logic                 fits;

    assign trial = {rem_reg, nq_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            nq_reg  <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            nq_reg  <= {nq_reg[DIV_N_W-2:0], fits};
            rem_reg <= fits ? DIV_D_W'(trial - {1'b0, den_reg}) : DIV_D_W'(trial);
        end
    end

    assign done = done_reg;
    assign q    = nq_reg;

endmodule
`default_nettype wire

>>> design/omni_pid_wheel_duty_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Three-axis PID (x, y, yaw) with clamped integral and filtered derivative,
// mixed into four omni-wheel speeds, each turned into a direction bit and a
// duty in 0.01% units (0 in the dead zone, else 50%..ceiling). One input
// transfer carries the three errors, one output transfer the four wheels.
// Items are handled one at a time by a sequencer around a bit-serial
// shift-add multiplier and a restoring divider; an item takes nine axis
// products, three mixing products, four wheel products and up to seven
// divisions. A new input is taken once the previous item has moved its
// results into the output register, even while that register waits.
// Configuration writes are taken at any time but belong in idle periods.
module omni_pid_wheel_duty_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // err_x [15:0], err_y [31:16], err_yaw [47:32]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // duty_w1 [13:0], fwd_w1 [14], duty_w2 [28:15], fwd_w2 [29],
    // duty_w3 [43:30], fwd_w3 [44], duty_w4 [58:45], fwd_w4 [59], zero pad
    output logic [63:0]      m_tdata
);
    import opwd_pkg::*;

    // configuration
    logic [GAIN_W-1:0] kp_xy_reg, ki_xy_reg, kd_xy_reg;
    logic [GAIN_W-1:0] kp_yaw_reg, ki_yaw_reg, kd_yaw_reg;
    logic [DUTY_W-1:0] ceil_reg;
    logic [GAIN_W-1:0] stp_reg;

    // sequencer
    state_t      state_reg, state_next;
    logic [1:0]  ax_reg;
    logic [1:0]  wh_reg;

    // per-axis loop state
    logic signed [ERR_W-1:0]   err_reg   [3];
    logic signed [ERR_W-1:0]   last_reg  [3];
    logic signed [ACC_W-1:0]   acc_reg   [3];
    logic signed [SLOPE_W-1:0] slope_reg [3];
    logic signed [PID_W-1:0]   pid_reg   [3];

    logic signed [ERR_W-1:0]  e_reg;
    logic signed [PROD_W-1:0] pid_sum_reg;
    logic signed [PROD_W-1:0] mix_a_reg, mix_b_reg, mix_c_reg;
    logic [PCT_W-1:0]         pct_reg;
    logic [DUTY_W-1:0]        duty_reg [4];
    logic                     fwd_reg  [4];

    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;

    // shared serial units
    mul_req_t                 mul_req;
    logic                     mul_done;
    logic signed [PROD_W-1:0] mul_p;
    div_req_t                 div_req;
    logic                     div_done;
    logic [DIV_N_W-1:0]       div_q;

    opwd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .p     (mul_p)
    );

    opwd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .q     (div_q)
    );

    // yaw error clamped to +/-0.5 on entry
    localparam logic signed [ERR_W-1:0] YAW_HALF = ERR_W'(1 << (FRAC_BITS - 1));
    logic signed [ERR_W-1:0] yaw_in;
    logic signed [ERR_W-1:0] yaw_clamped;
    assign yaw_in      = s_tdata[47:32];
    assign yaw_clamped = (yaw_in > YAW_HALF) ? YAW_HALF :
                         (yaw_in < -YAW_HALF) ? -YAW_HALF : yaw_in;

    // gain selection per axis
    logic [GAIN_W-1:0] kp_sel, ki_sel, kd_sel;
    assign kp_sel = (ax_reg == 2'd2) ? kp_yaw_reg : kp_xy_reg;
    assign ki_sel = (ax_reg == 2'd2) ? ki_yaw_reg : ki_xy_reg;
    assign kd_sel = (ax_reg == 2'd2) ? kd_yaw_reg : kd_xy_reg;

    // derivative filter: floor((old + 20*delta) / 2)
    logic signed [ERR_W-1:0]   e_cur;
    logic signed [ERR_W:0]     diff;
    logic signed [21:0]        raw;
    logic signed [SLOPE_W:0]   sl_sum;
    logic [ERR_W-1:0]          mag_e;
    assign e_cur  = err_reg[ax_reg];
    assign diff   = (ERR_W+1)'(e_cur) - (ERR_W+1)'(last_reg[ax_reg]);
    assign raw    = 22'(22'(diff) * 22'sd20);
    assign sl_sum = (SLOPE_W+1)'(slope_reg[ax_reg]) + (SLOPE_W+1)'(raw);
    assign mag_e  = e_cur[ERR_W-1] ? ERR_W'(-e_cur) : e_cur;

    // integral step with clamp to +/-1.0
    localparam logic signed [ACC_W:0] ACC_ONE = (ACC_W+1)'(1 << FRAC_BITS);
    logic signed [ACC_W:0] inc;
    logic signed [ACC_W:0] acc_sum;
    logic signed [ACC_W-1:0] acc_new;
    assign inc     = e_reg[ERR_W-1] ? -(ACC_W+1)'(div_q[ACC_W:0])
                                    : (ACC_W+1)'(div_q[ACC_W:0]);
    assign acc_sum = (ACC_W+1)'(acc_reg[ax_reg]) + inc;
    assign acc_new = (acc_sum > ACC_ONE) ? ACC_W'(ACC_ONE) :
                     (acc_sum < -ACC_ONE) ? ACC_W'(-ACC_ONE) : ACC_W'(acc_sum);

    // pid rounding, ties toward +inf
    logic signed [PROD_W-1:0] pid_rnd;
    assign pid_rnd = pid_sum_reg + PROD_W'(8192);

    // wheel speed and its rounded magnitude
    logic signed [PROD_W-1:0] speed;
    logic [PROD_W-1:0]        mag_s;
    logic [PROD_W:0]          mag_rnd;
    logic [MUL_A_W-1:0]       m_val;
    always_comb
    begin
        unique case (wh_reg)
            2'd0:    speed = mix_a_reg + mix_b_reg + mix_c_reg;
            2'd1:    speed = mix_a_reg - mix_b_reg + mix_c_reg;
            2'd2:    speed = -mix_a_reg - mix_b_reg + mix_c_reg;
            default: speed = -mix_a_reg + mix_b_reg + mix_c_reg;
        endcase
    end
    assign mag_s   = speed[PROD_W-1] ? PROD_W'(-speed) : PROD_W'(speed);
    assign mag_rnd = (PROD_W+1)'(mag_s) + (PROD_W+1)'(32768);
    assign m_val   = mag_rnd[MUL_A_W+15:16];

    // percent in 0.01% units from the scaled product, capped
    logic [34:0]      pct_wide;
    logic [PCT_W-1:0] pct_raw;
    logic [PCT_W-1:0] pct_val;
    assign pct_wide = 35'(mul_p[27:0]) * 35'd100;
    assign pct_raw  = pct_wide[34:20];
    assign pct_val  = (mul_p[PROD_W-1:20] > 28'd200) ? PCT_CAP :
                      (pct_raw > PCT_CAP) ? PCT_CAP : pct_raw;

    // remap into 50%..ceiling
    logic [DUTY_W-1:0]  ceil_eff;
    logic [DIV_N_W-1:0] remap_num;
    logic [DUTY_W-1:0]  duty_sum;
    logic [DUTY_W-1:0]  duty_new;
    assign ceil_eff  = (ceil_reg < DUTY_FLOOR) ? DUTY_FLOOR :
                       (ceil_reg > DUTY_TOP) ? DUTY_TOP : ceil_reg;
    assign remap_num = DIV_N_W'(pct_reg) * DIV_N_W'(ceil_eff - DUTY_FLOOR);
    assign duty_sum  = DUTY_W'(div_q) + DUTY_FLOOR;
    assign duty_new  = (duty_sum > ceil_eff) ? ceil_eff : duty_sum;

    logic in_xfer;
    logic out_free;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_AX_PREP;
            S_AX_PREP: state_next = S_AX_INC;
            S_AX_INC:  if (div_done) state_next = S_AX_MP;
            S_AX_MP:   if (mul_done) state_next = S_AX_MI;
            S_AX_MI:   if (mul_done) state_next = S_AX_MD;
            S_AX_MD:   if (mul_done) state_next = S_AX_END;
            S_AX_END:  state_next = (ax_reg == 2'd2) ? S_MX_A : S_AX_PREP;
            S_MX_A:    if (mul_done) state_next = S_MX_B;
            S_MX_B:    if (mul_done) state_next = S_MX_C;
            S_MX_C:    if (mul_done) state_next = S_WH_PREP;
            S_WH_PREP: state_next = S_WH_MUL;
            S_WH_MUL:  if (mul_done) state_next = S_WH_SCL;
            S_WH_SCL:
            begin
                if (pct_reg >= DEAD_ZONE)
                    state_next = S_WH_DIV;
                else
                    state_next = (wh_reg == 2'd3) ? S_DONE : S_WH_PREP;
            end
            S_WH_DIV:
            begin
                if (div_done)
                    state_next = (wh_reg == 2'd3) ? S_DONE : S_WH_PREP;
            end
            S_DONE:    if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // unit requests and handshake
    always_comb
    begin
        mul_req  = '0;
        div_req  = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:    s_tready = 1'b1;
            S_AX_PREP:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_N_W'(mag_e) + DIV_N_W'(10);
                div_req.den   = INTEG_DIV;
            end
            S_AX_INC:
            begin
                mul_req.start = div_done;
                mul_req.a     = MUL_A_W'(e_reg);
                mul_req.b     = kp_sel;
            end
            S_AX_MP:
            begin
                mul_req.start = mul_done;
                mul_req.a     = MUL_A_W'(acc_reg[ax_reg]);
                mul_req.b     = ki_sel;
            end
            S_AX_MI:
            begin
                mul_req.start = mul_done;
                mul_req.a     = MUL_A_W'(slope_reg[ax_reg]);
                mul_req.b     = kd_sel;
            end
            S_AX_END:
            begin
                mul_req.start = (ax_reg == 2'd2);
                mul_req.a     = MUL_A_W'(pid_reg[0]);
                mul_req.b     = INV_SQRT2_Q16;
            end
            S_MX_A:
            begin
                mul_req.start = mul_done;
                mul_req.a     = MUL_A_W'(pid_reg[1]);
                mul_req.b     = INV_SQRT2_Q16;
            end
            S_MX_B:
            begin
                mul_req.start = mul_done;
                mul_req.a     = MUL_A_W'(pid_reg[2]);
                mul_req.b     = RADIUS_Q16;
            end
            S_WH_PREP:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = m_val;
                mul_req.b     = stp_reg;
            end
            S_WH_SCL:
            begin
                div_req.start = (pct_reg >= DEAD_ZONE);
                div_req.num   = remap_num;
                div_req.den   = REMAP_DIV;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ax_reg       <= '0;
            wh_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            kp_xy_reg    <= RST_KP_XY;
            ki_xy_reg    <= RST_KI_XY;
            kd_xy_reg    <= RST_KD_XY;
            kp_yaw_reg   <= RST_KP_YAW;
            ki_yaw_reg   <= RST_KI_YAW;
            kd_yaw_reg   <= RST_KD_YAW;
            ceil_reg     <= RST_CEIL;
            stp_reg      <= RST_STP;
            for (int i = 0; i < 3; i++)
            begin
                last_reg[i]  <= '0;
                acc_reg[i]   <= '0;
                slope_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_addr))
                    REG_KP_XY:  kp_xy_reg  <= cfg_data;
                    REG_KI_XY:  ki_xy_reg  <= cfg_data;
                    REG_KD_XY:  kd_xy_reg  <= cfg_data;
                    REG_KP_YAW: kp_yaw_reg <= cfg_data;
                    REG_KI_YAW: ki_yaw_reg <= cfg_data;
                    REG_KD_YAW: kd_yaw_reg <= cfg_data;
                    REG_CEIL:   ceil_reg   <= cfg_data[DUTY_W-1:0];
                    REG_STP:    stp_reg    <= cfg_data;
                    default:    ;
                endcase
            end

            if (in_xfer)
                ax_reg <= '0;
            else if (state_reg == S_AX_END)
                ax_reg <= ax_reg + 1'b1;

            if (state_reg == S_MX_C)
                wh_reg <= '0;
            else if ((state_reg == S_WH_SCL && pct_reg < DEAD_ZONE) ||
                     (state_reg == S_WH_DIV && div_done))
                wh_reg <= wh_reg + 1'b1;

            // loop state moves once per axis
            if (state_reg == S_AX_PREP)
            begin
                last_reg[ax_reg]  <= e_cur;
                slope_reg[ax_reg] <= sl_sum[SLOPE_W:1];
            end
            if (state_reg == S_AX_INC && div_done)
                acc_reg[ax_reg] <= acc_new;

            if (state_reg == S_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            err_reg[0] <= s_tdata[15:0];
            err_reg[1] <= s_tdata[31:16];
            err_reg[2] <= yaw_clamped;
        end
        if (state_reg == S_AX_PREP)
            e_reg <= e_cur;

        // pid sum over the three gain products, mixing products, wheel percent
        if (mul_done)
        begin
            unique case (state_reg)
                S_AX_MP: pid_sum_reg <= mul_p;
                S_AX_MI: pid_sum_reg <= pid_sum_reg + mul_p;
                S_AX_MD: pid_sum_reg <= pid_sum_reg + mul_p;
                S_MX_A:  mix_a_reg   <= mul_p;
                S_MX_B:  mix_b_reg   <= mul_p;
                S_MX_C:  mix_c_reg   <= mul_p;
                S_WH_MUL: pct_reg    <= pct_val;
                default: ;
            endcase
        end
        if (state_reg == S_AX_END)
            pid_reg[ax_reg] <= pid_rnd[PID_W+13:14];

        // wheel outputs, dead zone gives zero duty
        if (state_reg == S_WH_PREP)
            fwd_reg[wh_reg] <= !speed[PROD_W-1] && (speed != '0);
        if (state_reg == S_WH_SCL && pct_reg < DEAD_ZONE)
            duty_reg[wh_reg] <= '0;
        if (state_reg == S_WH_DIV && div_done)
            duty_reg[wh_reg] <= duty_new;

        if (state_reg == S_DONE && out_free)
            m_tdata_reg <= {4'b0000,
                            fwd_reg[3], duty_reg[3], fwd_reg[2], duty_reg[2],
                            fwd_reg[1], duty_reg[1], fwd_reg[0], duty_reg[0]};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire
